/* sv/fmst_pkg.sv */
// Shared types, codes and ROM tables for the FM timer and sine tone block.
package fmst_pkg;

  localparam int unsigned NumChan = 6;
  localparam int unsigned ChanW = 3;

  typedef enum logic [2:0] {
    KIND_ADDR1 = 3'd0,
    KIND_ADDR2 = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_STAT  = 3'd3,
    KIND_TICK  = 3'd4
  } kind_e;

  localparam logic [7:0] RegTimerAHi = 8'h24;
  localparam logic [7:0] RegTimerALo = 8'h25;
  localparam logic [7:0] RegTimerB   = 8'h26;
  localparam logic [7:0] RegTimerCtl = 8'h27;
  localparam logic [7:0] RegKeyOn    = 8'h28;
  localparam logic [7:0] RegDacData  = 8'h2a;
  localparam logic [7:0] RegDacEn    = 8'h2b;
  localparam logic [7:0] RegFnumLo0  = 8'ha0;
  localparam logic [7:0] RegFnumLo2  = 8'ha2;
  localparam logic [7:0] RegFnumHi0  = 8'ha4;
  localparam logic [7:0] RegFnumHi2  = 8'ha6;
  localparam logic [11:0] Atten      = 12'd1536;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           wr_addr;
    logic           grp;
    logic           wr_data;
    logic           tick_timers;
    logic           clr_sum;
    logic           chan_step;
    logic [ChanW-1:0] chan;
  } fmst_cmd_t;

  function automatic logic [2:0] key_chan(input logic [2:0] sel);
    case (sel)
      3'd0: key_chan = 3'd0;
      3'd1: key_chan = 3'd1;
      3'd2: key_chan = 3'd2;
      3'd4: key_chan = 3'd3;
      3'd5: key_chan = 3'd4;
      3'd6: key_chan = 3'd5;
      default: key_chan = 3'd0;
    endcase
  endfunction

  localparam logic [11:0] LogSine [256] = '{
    12'h859,12'h6c3,12'h607,12'h58b,12'h52e,12'h4e4,12'h4a6,12'h471,12'h443,12'h41a,12'h3f5,
    12'h3d3,12'h3b5,12'h398,12'h37e,12'h365,
    12'h34e,12'h339,12'h324,12'h311,12'h2ff,12'h2ed,12'h2dc,12'h2cd,12'h2bd,12'h2af,12'h2a0,
    12'h293,12'h286,12'h279,12'h26d,12'h261,
    12'h256,12'h24b,12'h240,12'h236,12'h22c,12'h222,12'h218,12'h20f,12'h206,12'h1fd,12'h1f5,
    12'h1ec,12'h1e4,12'h1dc,12'h1d4,12'h1cd,
    12'h1c5,12'h1be,12'h1b7,12'h1b0,12'h1a9,12'h1a2,12'h19b,12'h195,12'h18f,12'h188,12'h182,
    12'h17c,12'h177,12'h171,12'h16b,12'h166,
    12'h160,12'h15b,12'h155,12'h150,12'h14b,12'h146,12'h141,12'h13c,12'h137,12'h133,12'h12e,
    12'h129,12'h125,12'h121,12'h11c,12'h118,
    12'h114,12'h10f,12'h10b,12'h107,12'h103,12'h0ff,12'h0fb,12'h0f8,12'h0f4,12'h0f0,12'h0ec,
    12'h0e9,12'h0e5,12'h0e2,12'h0de,12'h0db,
    12'h0d7,12'h0d4,12'h0d1,12'h0cd,12'h0ca,12'h0c7,12'h0c4,12'h0c1,12'h0be,12'h0bb,12'h0b8,
    12'h0b5,12'h0b2,12'h0af,12'h0ac,12'h0a9,
    12'h0a7,12'h0a4,12'h0a1,12'h09f,12'h09c,12'h099,12'h097,12'h094,12'h092,12'h08f,12'h08d,
    12'h08a,12'h088,12'h086,12'h083,12'h081,
    12'h07f,12'h07d,12'h07a,12'h078,12'h076,12'h074,12'h072,12'h070,12'h06e,12'h06c,12'h06a,
    12'h068,12'h066,12'h064,12'h062,12'h060,
    12'h05e,12'h05c,12'h05b,12'h059,12'h057,12'h055,12'h053,12'h052,12'h050,12'h04e,12'h04d,
    12'h04b,12'h04a,12'h048,12'h046,12'h045,
    12'h043,12'h042,12'h040,12'h03f,12'h03e,12'h03c,12'h03b,12'h039,12'h038,12'h037,12'h035,
    12'h034,12'h033,12'h031,12'h030,12'h02f,
    12'h02e,12'h02d,12'h02b,12'h02a,12'h029,12'h028,12'h027,12'h026,12'h025,12'h024,12'h023,
    12'h022,12'h021,12'h020,12'h01f,12'h01e,
    12'h01d,12'h01c,12'h01b,12'h01a,12'h019,12'h018,12'h017,12'h017,12'h016,12'h015,12'h014,
    12'h014,12'h013,12'h012,12'h011,12'h011,
    12'h010,12'h00f,12'h00f,12'h00e,12'h00d,12'h00d,12'h00c,12'h00c,12'h00b,12'h00a,12'h00a,
    12'h009,12'h009,12'h008,12'h008,12'h007,
    12'h007,12'h007,12'h006,12'h006,12'h005,12'h005,12'h005,12'h004,12'h004,12'h004,12'h003,
    12'h003,12'h003,12'h002,12'h002,12'h002,
    12'h002,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,12'h000,12'h000,12'h000,
    12'h000,12'h000,12'h000,12'h000,12'h000
  };

  localparam logic [10:0] ExpTab [256] = '{
    11'h7fa,11'h7f5,11'h7ef,11'h7ea,11'h7e4,11'h7df,11'h7da,11'h7d4,11'h7cf,11'h7c9,11'h7c4,
    11'h7bf,11'h7b9,11'h7b4,11'h7ae,11'h7a9,
    11'h7a4,11'h79f,11'h799,11'h794,11'h78f,11'h78a,11'h784,11'h77f,11'h77a,11'h775,11'h770,
    11'h76a,11'h765,11'h760,11'h75b,11'h756,
    11'h751,11'h74c,11'h747,11'h742,11'h73d,11'h738,11'h733,11'h72e,11'h729,11'h724,11'h71f,
    11'h71a,11'h715,11'h710,11'h70b,11'h706,
    11'h702,11'h6fd,11'h6f8,11'h6f3,11'h6ee,11'h6e9,11'h6e5,11'h6e0,11'h6db,11'h6d6,11'h6d2,
    11'h6cd,11'h6c8,11'h6c4,11'h6bf,11'h6ba,
    11'h6b5,11'h6b1,11'h6ac,11'h6a8,11'h6a3,11'h69e,11'h69a,11'h695,11'h691,11'h68c,11'h688,
    11'h683,11'h67f,11'h67a,11'h676,11'h671,
    11'h66d,11'h668,11'h664,11'h65f,11'h65b,11'h657,11'h652,11'h64e,11'h649,11'h645,11'h641,
    11'h63c,11'h638,11'h634,11'h630,11'h62b,
    11'h627,11'h623,11'h61e,11'h61a,11'h616,11'h612,11'h60e,11'h609,11'h605,11'h601,11'h5fd,
    11'h5f9,11'h5f5,11'h5f0,11'h5ec,11'h5e8,
    11'h5e4,11'h5e0,11'h5dc,11'h5d8,11'h5d4,11'h5d0,11'h5cc,11'h5c8,11'h5c4,11'h5c0,11'h5bc,
    11'h5b8,11'h5b4,11'h5b0,11'h5ac,11'h5a8,
    11'h5a4,11'h5a0,11'h59c,11'h599,11'h595,11'h591,11'h58d,11'h589,11'h585,11'h581,11'h57e,
    11'h57a,11'h576,11'h572,11'h56f,11'h56b,
    11'h567,11'h563,11'h560,11'h55c,11'h558,11'h554,11'h551,11'h54d,11'h549,11'h546,11'h542,
    11'h53e,11'h53b,11'h537,11'h534,11'h530,
    11'h52c,11'h529,11'h525,11'h522,11'h51e,11'h51b,11'h517,11'h514,11'h510,11'h50c,11'h509,
    11'h506,11'h502,11'h4ff,11'h4fb,11'h4f8,
    11'h4f4,11'h4f1,11'h4ed,11'h4ea,11'h4e7,11'h4e3,11'h4e0,11'h4dc,11'h4d9,11'h4d6,11'h4d2,
    11'h4cf,11'h4cc,11'h4c8,11'h4c5,11'h4c2,
    11'h4be,11'h4bb,11'h4b8,11'h4b5,11'h4b1,11'h4ae,11'h4ab,11'h4a8,11'h4a4,11'h4a1,11'h49e,
    11'h49b,11'h498,11'h494,11'h491,11'h48e,
    11'h48b,11'h488,11'h485,11'h482,11'h47e,11'h47b,11'h478,11'h475,11'h472,11'h46f,11'h46c,
    11'h469,11'h466,11'h463,11'h460,11'h45d,
    11'h45a,11'h457,11'h454,11'h451,11'h44e,11'h44b,11'h448,11'h445,11'h442,11'h43f,11'h43c,
    11'h439,11'h436,11'h433,11'h430,11'h42d,
    11'h42a,11'h428,11'h425,11'h422,11'h41f,11'h41c,11'h419,11'h416,11'h414,11'h411,11'h40e,
    11'h40b,11'h408,11'h406,11'h403,11'h400
  };

endpackage

/* sv/fm_sound_chip_timers_and_sine_tones.sv */
// Top level of the FM timer and sine tone block.
// A status read returns its result the cycle after it is taken. A sample tick
// steps the timers and clears the sum as it is taken, then steps the six channels
// one at a time through the shared log-sine and exp lookup and accumulator, then
// registers the mixed level. In DAC mode the last channel adds the DAC byte.
// The next transaction is taken once the result register has been emptied.
module fm_sound_chip_timers_and_sine_tones (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  logic [7:0]        bus_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        status_byte_o,
  output logic signed [9:0] mixed_level_o,
  output logic              is_level_o
);
  import fmst_pkg::*;

  fmst_cmd_t  cmd;
  logic [1:0] flags;
  logic [9:0] sum;

  fmst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .status_byte_o, .mixed_level_o, .is_level_o,
    .cmd_o(cmd), .flags_i(flags), .sum_i(sum)
  );

  fmst_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .bus_value_i,
    .flags_o(flags), .sum_o(sum)
  );

endmodule

/* sv/fmst_datapath.sv */
// Register file, timers, phase accumulators, sine lookup and level mixer.
module fmst_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fmst_pkg::fmst_cmd_t cmd_i,
  input  logic [7:0]        bus_value_i,
  output logic [1:0]        flags_o,
  output logic [9:0]        sum_o
);
  import fmst_pkg::*;

  logic [7:0]  addr_q;
  logic        grp_q;
  logic [9:0]  ta_rel_q;
  logic [7:0]  tb_rel_q;
  logic [10:0] ta_cnt_q;
  logic [8:0]  tb_cnt_q;
  logic [3:0]  tb_pre_q;
  logic [7:0]  tctl_q;
  logic [1:0]  flags_q;
  logic [NumChan-1:0] key_q;
  logic [7:0]  fhi_q   [NumChan];
  logic [16:0] step_q  [NumChan];
  logic [19:0] phase_q [NumChan];
  logic [7:0]  dac_q;
  logic [7:0]  dac_mode_q;
  logic [9:0]  sum_q;

  // Data write decode
  logic [2:0]  base;
  logic        is_lo, is_hi;
  logic [2:0]  fch;
  logic [10:0] fnum;
  logic [17:0] fsh;
  logic [2:0]  kch;
  logic [7:0]  d;

  assign d     = bus_value_i;
  assign base  = grp_q ? 3'd3 : 3'd0;
  assign is_lo = (addr_q >= RegFnumLo0) && (addr_q <= RegFnumLo2);
  assign is_hi = (addr_q >= RegFnumHi0) && (addr_q <= RegFnumHi2);
  assign fch   = base + (is_lo ? 3'(addr_q - RegFnumLo0) : 3'(addr_q - RegFnumHi0));
  assign fnum  = {fhi_q[fch][2:0], d};
  assign fsh   = 18'({7'd0, fnum} << fhi_q[fch][5:3]);
  assign kch   = key_chan(d[2:0]);

  // Channel level for the channel being stepped
  logic [19:0] ph_new;
  logic [9:0]  p;
  logic [7:0]  idx;
  logic [11:0] att;
  logic [11:0] mag;
  logic [9:0]  lvl;
  logic [7:0]  dac_lvl;

  assign ph_new  = phase_q[cmd_i.chan] + 20'(step_q[cmd_i.chan]);
  assign p       = ph_new[19:10];
  assign idx     = p[8] ? ~p[7:0] : p[7:0];
  assign att     = LogSine[idx] + Atten;
  assign mag     = 12'(({ExpTab[att[7:0]], 1'b0} >> att[11:8]) >> 1);
  assign lvl     = p[9] ? 10'(-mag) : 10'(mag);
  assign dac_lvl = dac_q - 8'd128;
  logic use_dac;
  assign use_dac = (cmd_i.chan == 3'(NumChan - 1)) && dac_mode_q[7];

  logic [10:0] ta_inc;
  logic [8:0]  tb_inc;
  logic [3:0]  pre_inc;
  assign ta_inc  = ta_cnt_q + 11'd1;
  assign tb_inc  = tb_cnt_q + 9'd1;
  assign pre_inc = tb_pre_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0; grp_q <= 1'b0; ta_rel_q <= '0; tb_rel_q <= '0;
      ta_cnt_q <= '0; tb_cnt_q <= '0; tb_pre_q <= '0; tctl_q <= '0;
      flags_q <= '0; key_q <= '0; dac_q <= '0; dac_mode_q <= '0; sum_q <= '0;
      for (int i = 0; i < NumChan; i++) begin
        fhi_q[i] <= '0; step_q[i] <= '0; phase_q[i] <= '0;
      end
    end else begin
      if (cmd_i.wr_addr) begin
        addr_q <= d;
        grp_q  <= cmd_i.grp;
      end
      if (cmd_i.wr_data) begin
        if (is_lo) begin
          step_q[fch] <= fsh[17:1];
        end else if (is_hi) begin
          fhi_q[fch] <= d;
        end else if (!grp_q) begin
          case (addr_q)
            RegTimerAHi: ta_rel_q[9:2] <= d;
            RegTimerALo: ta_rel_q[1:0] <= d[1:0];
            RegTimerB:   tb_rel_q <= d;
            RegTimerCtl: begin
              if (!tctl_q[0] && d[0]) ta_cnt_q <= {1'b0, ta_rel_q};
              if (!tctl_q[1] && d[1]) tb_cnt_q <= {1'b0, tb_rel_q};
              tctl_q  <= d;
              flags_q <= flags_q & ~d[5:4];
            end
            RegKeyOn: begin
              if (!key_q[kch] && d[7]) phase_q[kch] <= '0;
              key_q[kch] <= d[7];
            end
            RegDacData: dac_q <= d;
            RegDacEn:   dac_mode_q <= d;
            default: ;
          endcase
        end
      end
      if (cmd_i.tick_timers) begin
        if (tctl_q[0]) begin
          if (ta_inc[10]) begin
            ta_cnt_q <= {1'b0, ta_rel_q};
            if (tctl_q[2]) flags_q[0] <= 1'b1;
          end else begin
            ta_cnt_q <= ta_inc;
          end
        end
        tb_pre_q <= pre_inc;
        if (tctl_q[1] && pre_inc == 4'd0) begin
          if (tb_inc[8]) begin
            tb_cnt_q <= {1'b0, tb_rel_q};
            if (tctl_q[3]) flags_q[1] <= 1'b1;
          end else begin
            tb_cnt_q <= tb_inc;
          end
        end
      end
      if (cmd_i.clr_sum) sum_q <= '0;
      if (cmd_i.chan_step) begin
        if (use_dac) begin
          sum_q <= sum_q + {{2{dac_lvl[7]}}, dac_lvl[7:0]};
        end else begin
          phase_q[cmd_i.chan] <= ph_new;
          sum_q <= sum_q + lvl;
        end
      end
    end
  end

  assign flags_o = flags_q;
  assign sum_o   = sum_q;

endmodule

/* sv/fmst_ctrl.sv */
// Sequencer: decodes transactions, steps channels and holds the result register.
module fmst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          status_byte_o,
  output logic signed [9:0]   mixed_level_o,
  output logic                is_level_o,
  output fmst_pkg::fmst_cmd_t cmd_o,
  input  logic [1:0]          flags_i,
  input  logic [9:0]          sum_i
);
  import fmst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CHAN, S_DONE} state_e;

  state_e state_q;
  logic [ChanW-1:0] chan_q;
  logic out_valid_q;
  logic [7:0] stat_q;
  logic [9:0] lvl_q;
  logic is_lvl_q;
  logic acc;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.chan = chan_q;
    cmd_o.grp = (kind_i == KIND_ADDR2);
    if (acc) begin
      cmd_o.wr_addr = (kind_i == KIND_ADDR1) || (kind_i == KIND_ADDR2);
      cmd_o.wr_data = (kind_i == KIND_DATA);
      cmd_o.tick_timers = (kind_i == KIND_TICK);
      cmd_o.clr_sum = (kind_i == KIND_TICK);
    end
    cmd_o.chan_step = (state_q == S_CHAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chan_q <= '0;
      out_valid_q <= 1'b0;
      stat_q <= '0;
      lvl_q <= '0;
      is_lvl_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc && kind_i == KIND_STAT) begin
            stat_q <= {6'd0, flags_i};
            lvl_q <= '0;
            is_lvl_q <= 1'b0;
            out_valid_q <= 1'b1;
          end else if (acc && kind_i == KIND_TICK) begin
            chan_q <= '0;
            state_q <= S_CHAN;
          end
        end
        S_CHAN: begin
          if (chan_q == 3'(NumChan - 1)) state_q <= S_DONE;
          else chan_q <= chan_q + 3'd1;
        end
        S_DONE: begin
          stat_q <= '0;
          lvl_q <= sum_i;
          is_lvl_q <= 1'b1;
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_byte_o = stat_q;
  assign mixed_level_o = lvl_q;
  assign is_level_o = is_lvl_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (out_valid_q && is_lvl_q)) else $error("tick lost");
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAN) |-> (chan_q < 3'(NumChan))) else $error("bad channel");
`endif

endmodule
